[hw/rtl/asert_pkg.sv]
// Shared types and constants for the ASERT next-target evaluator.
package asert_pkg;

	localparam int TARGET_BITS_DEF = 256;

	// Field widths
	localparam int T_W     = 34;
	localparam int H_W     = 31;
	localparam int SP_W    = 20;
	localparam int HL_W    = 32;
	localparam int CB_W    = 32;
	localparam int CFG_IDX_W = 2;

	// Schedule product, signed difference and its magnitude
	localparam int PROD_W  = SP_W + H_W + 1;
	localparam int DIFF_W  = PROD_W + 2;
	localparam int MAG_W   = PROD_W;
	localparam int FRAC_W  = 16;
	localparam int DVD_W   = MAG_W + FRAC_W;
	localparam int ES_W    = DIFF_W;

	// Divider: quotient bits resolved per pipeline stage
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = DVD_W / DIV_STEPS;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Register reset values
	localparam logic [CB_W-1:0] ANCHOR_RST  = 32'h1d00_ffff;
	localparam logic [CB_W-1:0] LIMIT_RST   = 32'h1d00_ffff;
	localparam logic [SP_W-1:0] SPACING_RST = 20'd600;
	localparam logic [HL_W-1:0] HL_RST      = 32'd172800;

	// Cubic 2^x approximation in Q16
	localparam logic [47:0] POLY_C1    = 48'd195766423245049;
	localparam logic [29:0] POLY_C2    = 30'd971821376;
	localparam logic [12:0] POLY_C3    = 13'd5127;
	localparam logic [63:0] POLY_ROUND = 64'h0000_8000_0000_0000;
	localparam logic [16:0] ONE_Q16    = 17'h1_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANCHOR    = 2'd0,
		REG_LIMIT     = 2'd1,
		REG_SPACING   = 2'd2,
		REG_HALF_LIFE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CB_W-1:0] anchor;
		logic [CB_W-1:0] limit;
		logic [SP_W-1:0] spacing;
		logic [HL_W-1:0] hl_secs;
	} cfg_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} mid_item_t;

	typedef struct packed {
		logic [HL_W-1:0]  rem;
		logic [DVD_W-1:0] nq;
		logic             neg;
	} div_st_t;

	typedef struct packed {
		logic adv;
		logic last_v;
		logic mid_pop;
		logic out_push;
	} back_stat_t;

endpackage

[hw/rtl/asert_fifo.sv]
// Small register FIFO used between the front, the back and the result port.
module asert_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == DEPTH_V);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + (AW+1)'(1);
				2'b01: cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/asert_front.sv]
// Front end: takes items, forms the schedule error and splits it into sign and magnitude.
module asert_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [asert_pkg::T_W-1:0] tdiff,
	input  logic [asert_pkg::H_W-1:0]    height_delta,
	input  logic [asert_pkg::SP_W-1:0]   spacing,
	input  logic                         out_full,
	output logic                         out_push,
	output asert_pkg::mid_item_t         out_item
);

	localparam int T_W    = asert_pkg::T_W;
	localparam int H_W    = asert_pkg::H_W;
	localparam int PROD_W = asert_pkg::PROD_W;
	localparam int DIFF_W = asert_pkg::DIFF_W;
	localparam int MAG_W  = asert_pkg::MAG_W;

	logic                     v_s1;
	logic signed [T_W-1:0]    t_s1;
	logic [H_W-1:0]           h_s1;
	logic                     v_s2;
	logic signed [T_W-1:0]    t_s2;
	logic [PROD_W-1:0]        prod_s2;

	logic                     adv;
	logic                     acc;
	logic [H_W:0]             hp1;
	logic [DIFF_W-1:0]        t_ext;
	logic [DIFF_W-1:0]        p_ext;
	logic [DIFF_W-1:0]        d_pos;
	logic [DIFF_W-1:0]        d_neg;

	assign adv  = !v_s2 || !out_full;
	assign full = v_s1 && !adv;
	assign acc  = push && !full;
	assign hp1  = {1'b0, h_s1} + (H_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s1 <= acc;
		end else if (!v_s1) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			t_s1 <= tdiff;
			h_s1 <= height_delta;
		end
		if (adv) begin
			t_s2    <= t_s1;
			prod_s2 <= PROD_W'(spacing) * PROD_W'(hp1);
		end
	end

	// both differences in parallel, sign picks the magnitude
	assign t_ext = {{(DIFF_W-T_W){t_s2[T_W-1]}}, t_s2};
	assign p_ext = {{(DIFF_W-PROD_W){1'b0}}, prod_s2};
	assign d_pos = t_ext - p_ext;
	assign d_neg = p_ext - t_ext;

	assign out_push     = v_s2 && !out_full;
	assign out_item.neg = d_pos[DIFF_W-1];
	assign out_item.mag = d_pos[DIFF_W-1] ? d_neg[MAG_W-1:0] : d_pos[MAG_W-1:0];

endmodule

[hw/rtl/asert_div.sv]
// Pipelined restoring divider: (magnitude * 2^16) / half-life, a few quotient bits per stage.
module asert_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_v,
	input  asert_pkg::mid_item_t              in_item,
	input  logic [asert_pkg::HL_W-1:0]        divisor,
	output logic                              out_v,
	output logic [asert_pkg::DVD_W-1:0]       out_quo,
	output logic                              out_neg
);

	localparam int NS    = asert_pkg::DIV_STAGES;
	localparam int STEPS = asert_pkg::DIV_STEPS;
	localparam int HL_W  = asert_pkg::HL_W;
	localparam int DVD_W = asert_pkg::DVD_W;
	localparam int FRAC_W = asert_pkg::FRAC_W;

	function automatic asert_pkg::div_st_t div_step(asert_pkg::div_st_t s, logic [HL_W-1:0] d);
		logic [HL_W:0]    r;
		logic [DVD_W-1:0] w;
		asert_pkg::div_st_t o;
		r = {1'b0, s.rem};
		w = s.nq;
		for (int i = 0; i < STEPS; i++) begin
			r = {r[HL_W-1:0], w[DVD_W-1]};
			w = {w[DVD_W-2:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				w[0] = 1'b1;
			end
		end
		o.rem = r[HL_W-1:0];
		o.nq  = w;
		o.neg = s.neg;
		return o;
	endfunction

	logic [NS-1:0]      v_s;
	asert_pkg::div_st_t st_s  [NS];
	asert_pkg::div_st_t nxt   [NS];
	asert_pkg::div_st_t init;

	// remaining dividend bits shift out of the top while quotient bits fill the bottom
	always_comb begin
		init.rem = '0;
		init.nq  = {in_item.mag, {FRAC_W{1'b0}}};
		init.neg = in_item.neg;
		nxt[0]   = div_step(init, divisor);
		for (int k = 1; k < NS; k++) begin
			nxt[k] = div_step(st_s[k-1], divisor);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NS-2:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NS; k++) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	assign out_v   = v_s[NS-1];
	assign out_quo = st_s[NS-1].nq;
	assign out_neg = st_s[NS-1].neg;

endmodule

[hw/rtl/asert_back.sv]
// Back end: divide, 2^x factor, scale and shift the anchor, clamp and compact-encode.
module asert_back #(
	parameter int TARGET_BITS = asert_pkg::TARGET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asert_pkg::cfg_t               cfg,
	input  logic                          mid_empty,
	input  asert_pkg::mid_item_t          mid_item,
	input  logic                          out_full,
	output logic [asert_pkg::CB_W-1:0]    out_code,
	output asert_pkg::back_stat_t         stat
);

	localparam int TB    = TARGET_BITS;
	localparam int SHA   = $clog2(TB);
	localparam int NB    = (TB + 7) / 8;
	localparam int BW    = NB * 8;
	localparam int SZW   = $clog2(NB + 1);
	localparam int ESW   = asert_pkg::ES_W;
	localparam int DVD_W = asert_pkg::DVD_W;
	localparam int FRAC_W = asert_pkg::FRAC_W;
	localparam int Q_W   = DVD_W - FRAC_W;
	localparam logic [SHA:0]          TB_SH = (SHA+1)'(TB);
	localparam logic signed [ESW-1:0] TB_ES = ESW'(TB);
	localparam logic [ESW-1:0]        TB_N  = ESW'(TB);
	localparam logic signed [ESW-1:0] ES_BIAS = ESW'(FRAC_W);

	typedef struct packed {
		logic [22:0] man;
		logic [10:0] sh;
	} cmp_t;

	// compact form split into a mantissa and a left shift
	function automatic cmp_t split_compact(logic [31:0] c);
		logic [7:0] sz;
		cmp_t       o;
		sz = c[31:24];
		if (sz <= 8'd3) begin
			o.man = c[22:0] >> {2'd3 - sz[1:0], 3'b000};
			o.sh  = '0;
		end else begin
			o.man = c[22:0];
			o.sh  = {sz - 8'd3, 3'b000};
		end
		return o;
	endfunction

	logic                  adv;
	logic                  dv;
	logic [DVD_W-1:0]      dquo;
	logic                  dneg;
	logic [asert_pkg::HL_W-1:0] hl_eff;
	cmp_t                  anc;
	cmp_t                  lsp;
	logic [TB-1:0]         lim;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	logic signed [ESW-1:0] es_s1, es_s2, es_s3, es_s4, es_s5, es_s6, es_s7;
	logic [15:0]           f_s1, f_s2;
	logic [31:0]           f2_s2;
	logic [63:0]           t1_s2, t1_s3;
	logic [63:0]           t2_s3;
	logic [47:0]           f3_s3;
	logic [63:0]           t3_s4, s12_s4;
	logic [16:0]           factor_s5;
	logic [39:0]           p_s6;
	logic [TB-1:0]         v_val_s7;
	logic [TB-1:0]         r_s8, r_s9, r_s10, r_s11;
	logic [NB-1:0]         nzb_s10;
	logic [SZW-1:0]        size_s11;
	logic [31:0]           code_s12;

	logic [Q_W-1:0]        q;
	logic [FRAC_W-1:0]     fr;
	logic signed [ESW-1:0] shifts;
	logic [63:0]           psum;
	logic [ESW-1:0]        nsh;
	logic [SHA:0]          tbm;
	logic [TB-1:0]         r8;
	logic [TB-1:0]         r9;
	logic [BW-1:0]         rx;
	logic [NB-1:0]         nzb;
	logic [SZW-1:0]        sz;
	logic [TB-1:0]         rs;
	logic [23:0]           cm;
	logic [7:0]            sz8;

	assign adv    = !v_s12 || !out_full;
	assign hl_eff = (cfg.hl_secs == '0) ? asert_pkg::HL_W'(1) : cfg.hl_secs;
	assign anc    = split_compact(cfg.anchor);
	assign lsp    = split_compact(cfg.limit);
	assign lim    = TB'(lsp.man) << lsp.sh;

	asert_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (!mid_empty),
		.in_item (mid_item),
		.divisor (hl_eff),
		.out_v   (dv),
		.out_quo (dquo),
		.out_neg (dneg)
	);

	// integer shift and fraction; negative values round toward minus infinity
	always_comb begin
		q  = dquo[DVD_W-1:FRAC_W];
		fr = dquo[FRAC_W-1:0];
		if (!dneg) begin
			shifts = ESW'(q);
		end else if (fr == '0) begin
			shifts = -ESW'(q);
		end else begin
			shifts = -ESW'(q) - ESW'(1);
		end
	end

	assign psum = s12_s4 + t3_s4 + asert_pkg::POLY_ROUND;

	// apply the net shift; a left shift that loses bits saturates to the limit
	always_comb begin
		nsh = -es_s7;
		tbm = TB_SH - {1'b0, es_s7[SHA-1:0]};
		if (es_s7[ESW-1] || es_s7 == '0) begin
			r8 = (nsh >= TB_N) ? '0 : (v_val_s7 >> nsh[SHA-1:0]);
		end else if (v_val_s7 == '0) begin
			r8 = '0;
		end else if (es_s7 >= TB_ES) begin
			r8 = lim;
		end else if ((v_val_s7 >> tbm[SHA-1:0]) != '0) begin
			r8 = lim;
		end else begin
			r8 = v_val_s7 << es_s7[SHA-1:0];
		end
	end

	always_comb begin
		if (r_s8 == '0) begin
			r9 = TB'(1);
		end else if (r_s8 > lim) begin
			r9 = lim;
		end else begin
			r9 = r_s8;
		end
	end

	always_comb begin
		rx = BW'(r_s9);
		for (int i = 0; i < NB; i++) begin
			nzb[i] = |rx[8*i +: 8];
		end
	end

	always_comb begin
		sz = '0;
		for (int i = 0; i < NB; i++) begin
			if (nzb_s10[i]) begin
				sz = SZW'(i + 1);
			end
		end
	end

	always_comb begin
		rs = r_s11 >> {size_s11 - SZW'(3), 3'b000};
		if (size_s11 <= SZW'(3)) begin
			cm = r_s11[23:0] << {2'd3 - size_s11[1:0], 3'b000};
		end else begin
			cm = rs[23:0];
		end
		sz8 = 8'(size_s11);
		if (cm[23]) begin
			cm  = cm >> 8;
			sz8 = sz8 + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else if (adv) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <=
				{dv, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			es_s1     <= shifts - ES_BIAS;
			f_s1      <= dneg ? (16'd0 - fr) : fr;

			es_s2     <= es_s1;
			f_s2      <= f_s1;
			f2_s2     <= 32'(f_s1) * 32'(f_s1);
			t1_s2     <= 64'(asert_pkg::POLY_C1) * 64'(f_s1);

			es_s3     <= es_s2;
			t1_s3     <= t1_s2;
			t2_s3     <= 64'(asert_pkg::POLY_C2) * 64'(f2_s2);
			f3_s3     <= 48'(f2_s2) * 48'(f_s2);

			es_s4     <= es_s3;
			s12_s4    <= t1_s3 + t2_s3;
			t3_s4     <= 64'(asert_pkg::POLY_C3) * 64'(f3_s3);

			es_s5     <= es_s4;
			factor_s5 <= asert_pkg::ONE_Q16 + {1'b0, psum[63:48]};

			es_s6     <= es_s5;
			p_s6      <= 40'(anc.man) * 40'(factor_s5);

			es_s7     <= es_s6;
			v_val_s7  <= TB'(p_s6) << anc.sh;

			r_s8      <= r8;
			r_s9      <= r9;

			r_s10     <= r_s9;
			nzb_s10   <= nzb;

			r_s11     <= r_s10;
			size_s11  <= sz;

			code_s12  <= {sz8, cm};
		end
	end

	assign out_code      = code_s12;
	assign stat.adv      = adv;
	assign stat.last_v   = v_s12;
	assign stat.mid_pop  = adv && !mid_empty;
	assign stat.out_push = v_s12 && !out_full;

endmodule

[hw/rtl/aserti3_2d_next_target_top.sv]
// Top level of the ASERT (aserti3-2d) next-target evaluator.
// Each item carries a signed time difference and a height difference from the
// anchor block; each gives exactly one compact (nBits) target, in order.
// Both sides look like queues: push/full in, empty/pop out. The block takes
// one item per clock and keeps that rate as long as results are popped.
// From push to empty going low, with the queues drained, an item passes
// the two front stages, the middle queue, the 34-stage divider (two
// quotient bits per stage over the 68-bit Q16 dividend) and twelve stages
// of polynomial, scaling, shifting, clamping and encoding.
// When the two-entry result queue fills, the back pipeline holds; the front
// keeps taking items until its four-entry queue fills, then raises full.
// Configuration registers (anchor, limit, spacing, half-life) are written
// through cfg_we/cfg_idx/cfg_wdata and must only change while no item is in
// flight. A half-life of zero is taken as one second.
module aserti3_2d_next_target_top #(
	parameter int TARGET_BITS = asert_pkg::TARGET_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [asert_pkg::T_W-1:0]     tdiff,
	input  logic [asert_pkg::H_W-1:0]            height_delta,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [asert_pkg::CB_W-1:0]           next_target_bits,
	input  logic                                 cfg_we,
	input  logic [asert_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [asert_pkg::CB_W-1:0]           cfg_wdata
);

	localparam int MID_W = $bits(asert_pkg::mid_item_t);

	// configuration registers
	logic [asert_pkg::CB_W-1:0] anchor_q;
	logic [asert_pkg::CB_W-1:0] limit_q;
	logic [asert_pkg::SP_W-1:0] spacing_q;
	logic [asert_pkg::HL_W-1:0] hl_secs_q;
	asert_pkg::cfg_t            cfg;

	// front -> middle queue -> back
	asert_pkg::mid_item_t  front_item;
	logic                  mid_push;
	logic                  mid_full;
	logic                  mid_empty;
	logic [MID_W-1:0]      mid_dout;
	asert_pkg::mid_item_t  mid_item;

	// back -> result queue
	asert_pkg::back_stat_t stat;
	logic [asert_pkg::CB_W-1:0] back_code;
	logic                  out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q    <= asert_pkg::ANCHOR_RST;
			limit_q     <= asert_pkg::LIMIT_RST;
			spacing_q   <= asert_pkg::SPACING_RST;
			hl_secs_q   <= asert_pkg::HL_RST;
		end else if (cfg_we) begin
			unique case (asert_pkg::cfg_reg_t'(cfg_idx))
				asert_pkg::REG_ANCHOR:    anchor_q    <= cfg_wdata;
				asert_pkg::REG_LIMIT:     limit_q     <= cfg_wdata;
				asert_pkg::REG_SPACING:   spacing_q   <= cfg_wdata[asert_pkg::SP_W-1:0];
				asert_pkg::REG_HALF_LIFE: hl_secs_q   <= cfg_wdata;
			endcase
		end
	end

	assign cfg.anchor    = anchor_q;
	assign cfg.limit     = limit_q;
	assign cfg.spacing   = spacing_q;
	assign cfg.hl_secs   = hl_secs_q;

	// front: schedule error, sign and magnitude
	asert_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.tdiff        (tdiff),
		.height_delta (height_delta),
		.spacing      (spacing_q),
		.out_full     (mid_full),
		.out_push     (mid_push),
		.out_item     (front_item)
	);

	// decouples the front from back-pipeline stalls
	asert_fifo #(
		.W     (MID_W),
		.DEPTH (asert_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (front_item),
		.full   (mid_full),
		.pop    (stat.mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty)
	);

	assign mid_item = asert_pkg::mid_item_t'(mid_dout);

	// back: divide, 2^x, scale, shift, clamp, encode
	asert_back #(
		.TARGET_BITS (TARGET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_empty (mid_empty),
		.mid_item  (mid_item),
		.out_full  (out_full),
		.out_code  (back_code),
		.stat      (stat)
	);

	// result queue; the head item sits on next_target_bits while empty is low
	asert_fifo #(
		.W     (asert_pkg::CB_W),
		.DEPTH (asert_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (stat.out_push),
		.din    (back_code),
		.full   (out_full),
		.pop    (pop),
		.dout   (next_target_bits),
		.empty  (empty)
	);

	// an item leaving the back always finds room in the result queue
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.out_push |-> !out_full)
		else $error("result pushed into full queue");

	// front only hands over an item when the middle queue has room
	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("item pushed into full middle queue");

	// the back pipeline holds only for a finished item facing a full result queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.adv |-> (stat.last_v && out_full))
		else $error("back pipeline held without cause");

	// the back pulls an item only while its pipeline advances
	a_pull_adv: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mid_pop |-> (stat.adv && !mid_empty))
		else $error("middle queue popped while back held");

endmodule
